// ===== hw/rtl/vcri_pkg.sv =====
// ----------------------------------------------------------------------------
// vcri_pkg
// Shared constants, register codes and reset values for the raster interrupt
// and register file block.
// ----------------------------------------------------------------------------
package vcri_pkg;

    localparam int REG_COUNT = 64;
    localparam int REG_IDX_W = $clog2(REG_COUNT);
    localparam int DATA_W    = 8;
    localparam int CYCLE_W   = 7;
    localparam int LINE_W    = 9;
    localparam int CFG_W     = 9;

    typedef logic [REG_IDX_W-1:0] reg_idx_t;

    localparam logic [15:0] BASE_ADDR = 16'hD000;

    // Transaction kinds.
    localparam logic [1:0] KIND_TICK  = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_WRITE = 2'd2;

    // Configuration register indexes.
    localparam logic CFG_CYCLES_PER_LINE = 1'b0;
    localparam logic CFG_LINES_PER_FRAME = 1'b1;

    localparam logic [CYCLE_W-1:0] CYCLES_PER_LINE_RESET = 7'd63;
    localparam logic [LINE_W-1:0]  LINES_PER_FRAME_RESET = 9'd312;

    // Register indexes with special behaviour.
    localparam reg_idx_t REG_CTRL1   = 6'h11;
    localparam reg_idx_t REG_RASTER  = 6'h12;
    localparam reg_idx_t REG_CTRL2   = 6'h16;
    localparam reg_idx_t REG_MEMPTR  = 6'h18;
    localparam reg_idx_t REG_LATCH   = 6'h19;
    localparam reg_idx_t REG_ENABLE  = 6'h1A;
    localparam reg_idx_t REG_COLL_SS = 6'h1E;
    localparam reg_idx_t REG_COLL_SD = 6'h1F;

    localparam logic [DATA_W-1:0] CTRL1_RESET  = 8'h9B;
    localparam logic [DATA_W-1:0] CTRL2_RESET  = 8'h08;
    localparam logic [DATA_W-1:0] MEMPTR_RESET = 8'h14;
    localparam logic [DATA_W-1:0] ENABLE_FORCE = 8'hF0;
    localparam logic [3:0]        SOURCE_MASK  = 4'hF;

    typedef struct packed {
        logic [1:0]        kind;
        reg_idx_t          idx;
        logic [DATA_W-1:0] data;
    } item_t;

    function automatic logic [DATA_W-1:0] reg_reset_value(input reg_idx_t idx);
        logic [DATA_W-1:0] v;
        v = '0;
        case (idx)
            REG_CTRL1:  v = CTRL1_RESET;
            REG_CTRL2:  v = CTRL2_RESET;
            REG_MEMPTR: v = MEMPTR_RESET;
            default:    v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== hw/rtl/vcri_ram.sv =====
// ----------------------------------------------------------------------------
// vcri_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module vcri_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // A read and a write to the same address in one cycle return the old data.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

endmodule

// ===== hw/rtl/video_chip_raster_irq_registers.sv =====
// ----------------------------------------------------------------------------
// video_chip_raster_irq_registers
// Raster counters, raster compare interrupt and 64-entry register file.
// ----------------------------------------------------------------------------
// A result passes the read-modify-write stage and then the output register.
// Throughput: one transaction per cycle unless the output stalls, set by the
// single read-modify-write stage around the register RAM, with the last write
// forwarded.
// Reset: counters, compare line, latch and enable clear; line length 63 and
// frame length 312; RAM entries read as their reset values until written.
// ----------------------------------------------------------------------------
module video_chip_raster_irq_registers (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic                          cfg_index,
    input  logic [vcri_pkg::CFG_W-1:0]    cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [1:0]                    kind,
    input  logic [15:0]                   address,
    input  logic [vcri_pkg::DATA_W-1:0]   write_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [vcri_pkg::DATA_W-1:0]   read_data,
    output logic                          irq,
    output logic [vcri_pkg::LINE_W-1:0]   raster_line,
    output logic [vcri_pkg::CYCLE_W-1:0]  raster_cycle
);

    import vcri_pkg::*;

    logic [CYCLE_W-1:0]   cycles_per_line_reg;
    logic [LINE_W-1:0]    lines_per_frame_reg;

    logic                 s1_valid_reg;
    item_t                s1_item_reg;
    logic                 out_valid_reg;
    logic [DATA_W-1:0]    read_data_reg;
    logic                 irq_reg;
    logic [LINE_W-1:0]    raster_line_reg;
    logic [CYCLE_W-1:0]   raster_cycle_reg;

    logic [CYCLE_W-1:0]   cycle_count_reg, cycle_count_next;
    logic [LINE_W-1:0]    line_count_reg, line_count_next;
    logic [LINE_W-1:0]    compare_line_reg, compare_line_next;
    logic [DATA_W-1:0]    latch_reg, latch_next;
    logic [DATA_W-1:0]    enable_reg, enable_next;

    logic [REG_COUNT-1:0] written_reg;
    logic                 fwd_valid_reg;
    reg_idx_t             fwd_idx_reg;
    logic [DATA_W-1:0]    fwd_data_reg;

    logic                 in_accept;
    logic                 s1_adv;
    reg_idx_t             in_idx;
    logic [15:0]          addr_offset;
    logic [DATA_W-1:0]    ram_q;
    logic [DATA_W-1:0]    mem_word;
    logic                 ram_we;
    logic [DATA_W-1:0]    ram_wdata;
    logic                 hit;
    logic [DATA_W-1:0]    latch_tick;
    logic [CYCLE_W-1:0]   cycle_inc;
    logic [LINE_W-1:0]    line_inc;
    logic [DATA_W-1:0]    rd_value;

    assign s1_adv    = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !s1_valid_reg || s1_adv;
    assign in_accept = in_valid && in_ready;

    assign addr_offset = address - BASE_ADDR;
    assign in_idx      = addr_offset[REG_IDX_W-1:0];

    vcri_ram #(
        .WIDTH (DATA_W),
        .DEPTH (REG_COUNT)
    ) u_regs (
        .clk   (clk),
        .we    (ram_we),
        .waddr (s1_item_reg.idx),
        .wdata (ram_wdata),
        .re    (in_accept),
        .raddr (in_idx),
        .rdata (ram_q)
    );

    // The most recent write is forwarded, as the RAM read may have been issued
    // in the same cycle as that write.
    always_comb
    begin
        if (fwd_valid_reg && fwd_idx_reg == s1_item_reg.idx)
        begin
            mem_word = fwd_data_reg;
        end
        else if (written_reg[s1_item_reg.idx])
        begin
            mem_word = ram_q;
        end
        else
        begin
            mem_word = reg_reset_value(s1_item_reg.idx);
        end
    end

    // Raster tick, then the register access.
    always_comb
    begin
        hit = (cycle_count_reg == 7'd1 && line_count_reg == compare_line_reg) ||
              (cycle_count_reg == 7'd2 && line_count_reg == '0 &&
               compare_line_reg == '0);
        latch_tick = latch_reg | {7'd0, hit};
        latch_tick[7] = |latch_tick[3:0];

        cycle_inc = cycle_count_reg + 7'd1;
        line_inc  = line_count_reg + 9'd1;
        cycle_count_next = cycle_inc;
        line_count_next  = line_count_reg;
        if (cycle_inc == cycles_per_line_reg)
        begin
            cycle_count_next = '0;
            line_count_next  = (line_inc == lines_per_frame_reg) ? '0 : line_inc;
        end

        latch_next        = latch_tick;
        enable_next       = enable_reg;
        compare_line_next = compare_line_reg;
        rd_value          = '0;
        ram_we            = 1'b0;
        ram_wdata         = '0;

        case (s1_item_reg.kind)
            KIND_READ:
            begin
                case (s1_item_reg.idx)
                    REG_CTRL1:   rd_value = {line_count_next[8], mem_word[6:0]};
                    REG_RASTER:  rd_value = line_count_next[7:0];
                    REG_LATCH:   rd_value = latch_tick;
                    REG_ENABLE:  rd_value = enable_reg;
                    REG_COLL_SS, REG_COLL_SD:
                    begin
                        rd_value = mem_word;
                        ram_we   = s1_adv;
                    end
                    default:     rd_value = mem_word;
                endcase
            end
            KIND_WRITE:
            begin
                ram_we    = s1_adv;
                ram_wdata = s1_item_reg.data;
                case (s1_item_reg.idx)
                    REG_CTRL1:  compare_line_next[8] = s1_item_reg.data[7];
                    REG_RASTER: compare_line_next[7:0] = s1_item_reg.data;
                    REG_LATCH:  latch_next = latch_tick & {4'd0, ~s1_item_reg.data[3:0]};
                    REG_ENABLE: enable_next = (s1_item_reg.data & {4'd0, SOURCE_MASK}) |
                                              ENABLE_FORCE;
                    default:    ;
                endcase
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cycles_per_line_reg <= CYCLES_PER_LINE_RESET;
            lines_per_frame_reg <= LINES_PER_FRAME_RESET;
            s1_valid_reg        <= 1'b0;
            out_valid_reg       <= 1'b0;
            cycle_count_reg     <= '0;
            line_count_reg      <= '0;
            compare_line_reg    <= '0;
            latch_reg           <= '0;
            enable_reg          <= '0;
            written_reg         <= '0;
            fwd_valid_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                if (cfg_index == CFG_CYCLES_PER_LINE)
                begin
                    cycles_per_line_reg <= cfg_data[CYCLE_W-1:0];
                end
                else
                begin
                    lines_per_frame_reg <= cfg_data[LINE_W-1:0];
                end
            end

            if (in_accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_adv)
            begin
                out_valid_reg    <= 1'b1;
                cycle_count_reg  <= cycle_count_next;
                line_count_reg   <= line_count_next;
                compare_line_reg <= compare_line_next;
                latch_reg        <= latch_next;
                enable_reg       <= enable_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (ram_we)
            begin
                written_reg[s1_item_reg.idx] <= 1'b1;
                fwd_valid_reg                <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_item_reg.kind <= kind;
            s1_item_reg.idx  <= in_idx;
            s1_item_reg.data <= write_data;
        end
        if (ram_we)
        begin
            fwd_idx_reg  <= s1_item_reg.idx;
            fwd_data_reg <= ram_wdata;
        end
        if (s1_adv)
        begin
            read_data_reg    <= rd_value;
            irq_reg          <= |(latch_next[3:0] & enable_next[3:0]);
            raster_line_reg  <= line_count_next;
            raster_cycle_reg <= cycle_count_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign read_data    = read_data_reg;
    assign irq          = irq_reg;
    assign raster_line  = raster_line_reg;
    assign raster_cycle = raster_cycle_reg;

    // A free output slot must never hold back the input side.
    a_no_bubble: assert property (@(posedge clk) disable iff (!rst_n)
        (!out_valid_reg || out_ready) |-> in_ready)
        else $error("input stalled while the output slot is free");

    // Latch bits 6..4 are never set by the tick or by an acknowledge.
    a_latch_unused: assert property (@(posedge clk) disable iff (!rst_n)
        latch_reg[6:4] == 3'd0)
        else $error("unused latch bits set");

    // The high nibble of the enable register is either still reset or forced.
    a_enable_high: assert property (@(posedge clk) disable iff (!rst_n)
        enable_reg[7:4] == 4'h0 || enable_reg[7:4] == 4'hF)
        else $error("enable register high nibble corrupted");

    // A forwarded entry is always marked as written.
    a_fwd_written: assert property (@(posedge clk) disable iff (!rst_n)
        fwd_valid_reg |-> written_reg[fwd_idx_reg])
        else $error("forwarded entry not marked as written");

endmodule

// ===== sim/tb_video_chip_raster_irq_registers.sv =====
// ----------------------------------------------------------------------------
// tb_video_chip_raster_irq_registers
// Self-checking bench for the raster counters, raster compare interrupt and
// register file. A shadow copy of the chip state predicts every result; a
// monitor compares each returned transaction with the oldest prediction, with
// both handshakes throttled at random in most phases. Directed register checks
// come first, then random phases across several line and frame lengths.
// ----------------------------------------------------------------------------
module tb_video_chip_raster_irq_registers;

    import vcri_pkg::*;

    localparam logic [1:0] KIND_SPARE     = 2'd3;
    localparam int         DRAIN_CYCLES   = 4;
    localparam int         WATCHDOG_LIMIT = 2000;

    typedef struct packed {
        logic [DATA_W-1:0]  read_data;
        logic               irq;
        logic [LINE_W-1:0]  line;
        logic [CYCLE_W-1:0] cycle;
    } raster_result_t;

    logic                clk;
    logic                rst_n      = 1'b0;
    logic                cfg_write  = 1'b0;
    logic                cfg_index  = 1'b0;
    logic [CFG_W-1:0]    cfg_data   = '0;
    logic                in_valid   = 1'b0;
    logic                in_ready;
    logic [1:0]          kind       = KIND_TICK;
    logic [15:0]         address    = '0;
    logic [DATA_W-1:0]   write_data = '0;
    logic                out_valid;
    logic                out_ready  = 1'b0;
    logic [DATA_W-1:0]   read_data;
    logic                irq;
    logic [LINE_W-1:0]   raster_line;
    logic [CYCLE_W-1:0]  raster_cycle;

    // Shadow of the chip state.
    logic [DATA_W-1:0]   shadow_regs [REG_COUNT];
    logic [LINE_W-1:0]   shadow_compare;
    logic [CYCLE_W-1:0]  shadow_cycle;
    logic [LINE_W-1:0]   shadow_line;
    logic [CYCLE_W-1:0]  line_length;
    logic [LINE_W-1:0]   frame_length;

    raster_result_t      pending_raster_results [$];
    raster_result_t      oldest_result;
    bit                  idle_on;
    int                  items_sent;
    int                  results_seen;
    int                  mismatch_count;
    int                  ready_hold;
    int                  quiet_cycles;

    video_chip_raster_irq_registers DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .kind         (kind),
        .address      (address),
        .write_data   (write_data),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .read_data    (read_data),
        .irq          (irq),
        .raster_line  (raster_line),
        .raster_cycle (raster_cycle)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void reset_shadow();
        for (int i = 0; i < REG_COUNT; i++)
        begin
            shadow_regs[i] = '0;
        end
        shadow_regs[REG_CTRL1]  = CTRL1_RESET;
        shadow_regs[REG_CTRL2]  = CTRL2_RESET;
        shadow_regs[REG_MEMPTR] = MEMPTR_RESET;
        shadow_compare = '0;
        shadow_cycle   = '0;
        shadow_line    = '0;
        line_length    = CYCLES_PER_LINE_RESET;
        frame_length   = LINES_PER_FRAME_RESET;
    endfunction

    // One chip clock: raster tick first, then the optional register access.
    function automatic raster_result_t clock_video_chip(input logic [1:0] op,
                                                        input logic [15:0] addr,
                                                        input logic [DATA_W-1:0] data);
        raster_result_t     res;
        logic [15:0]        offset;
        reg_idx_t           idx;
        logic [CYCLE_W-1:0] next_cycle;
        logic [LINE_W-1:0]  next_line;
        logic               hit;

        res    = '0;
        offset = addr - BASE_ADDR;
        idx    = offset[REG_IDX_W-1:0];

        hit = (shadow_cycle == 7'd1 && shadow_line == shadow_compare) ||
              (shadow_cycle == 7'd2 && shadow_line == '0 && shadow_compare == '0);
        if (hit)
            shadow_regs[REG_LATCH][0] = 1'b1;
        shadow_regs[REG_LATCH][7] = |shadow_regs[REG_LATCH][3:0];

        next_cycle = shadow_cycle + 7'd1;
        if (next_cycle == line_length)
        begin
            next_cycle = '0;
            next_line  = shadow_line + 9'd1;
            if (next_line == frame_length)
                next_line = '0;
            shadow_line = next_line;
        end
        shadow_cycle = next_cycle;

        if (op == KIND_READ)
        begin
            case (idx)
                REG_CTRL1:  res.read_data = {shadow_line[8], shadow_regs[idx][6:0]};
                REG_RASTER: res.read_data = shadow_line[7:0];
                REG_COLL_SS, REG_COLL_SD:
                begin
                    res.read_data    = shadow_regs[idx];
                    shadow_regs[idx] = '0;
                end
                default:    res.read_data = shadow_regs[idx];
            endcase
        end
        else if (op == KIND_WRITE)
        begin
            case (idx)
                REG_CTRL1:
                begin
                    shadow_regs[idx]  = data;
                    shadow_compare[8] = data[7];
                end
                REG_RASTER:
                begin
                    shadow_regs[idx]    = data;
                    shadow_compare[7:0] = data;
                end
                // Writing 1 acknowledges a latch bit; the request bit drops too.
                REG_LATCH:  shadow_regs[idx] = shadow_regs[idx] & {4'h0, ~data[3:0]};
                REG_ENABLE: shadow_regs[idx] = ENABLE_FORCE | {4'h0, data[3:0]};
                default:    shadow_regs[idx] = data;
            endcase
        end

        res.irq   = |(shadow_regs[REG_LATCH][3:0] & shadow_regs[REG_ENABLE][3:0]);
        res.line  = shadow_line;
        res.cycle = shadow_cycle;
        return res;
    endfunction

    // Predicts on input transactions and checks output transactions; the
    // prediction is pushed before the comparison so ordering within a step
    // cannot matter.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                pending_raster_results.push_back(clock_video_chip(kind, address,
                                                                  write_data));
            if (out_valid && out_ready)
            begin
                if (pending_raster_results.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("result with nothing expected: ",
                                 "rd=%02h irq=%0d line=%0d cycle=%0d",
                                 read_data, irq, raster_line, raster_cycle);
                end
                else
                begin
                    oldest_result = pending_raster_results.pop_front();
                    if (read_data !== oldest_result.read_data || irq !== oldest_result.irq ||
                        raster_line !== oldest_result.line ||
                        raster_cycle !== oldest_result.cycle)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("mismatch: expected rd=%02h irq=%0d line=%0d cycle=%0d,",
                                     oldest_result.read_data, oldest_result.irq,
                                     oldest_result.line, oldest_result.cycle,
                                     " got rd=%02h irq=%0d line=%0d cycle=%0d",
                                     read_data, irq, raster_line, raster_cycle);
                    end
                end
                results_seen++;
                ready_hold = idle_on ? $urandom_range(0, 4) : 0;
            end
            else if (ready_hold > 0)
            begin
                ready_hold--;
            end
            out_ready <= (ready_hold == 0);

            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("status: fail");
                $finish;
            end
        end
    end

    function automatic logic [15:0] bus_addr(input reg_idx_t idx);
        return BASE_ADDR + {10'd0, idx};
    endfunction

    task automatic send_item(input logic [1:0] op, input logic [15:0] addr,
                             input logic [DATA_W-1:0] data);
        int gap;
        gap = idle_on ? $urandom_range(0, 4) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        kind       <= op;
        address    <= addr;
        write_data <= data;
        do @(posedge clk); while (!in_ready);
        items_sent++;
    endtask

    task automatic wait_for_drain();
        in_valid <= 1'b0;
        while (results_seen < items_sent) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_config(input logic [CYCLE_W-1:0] cycles,
                                input logic [LINE_W-1:0] lines);
        wait_for_drain();
        cfg_write <= 1'b1;
        cfg_index <= CFG_CYCLES_PER_LINE;
        cfg_data  <= {2'b00, cycles};
        @(posedge clk);
        cfg_index <= CFG_LINES_PER_FRAME;
        cfg_data  <= lines;
        @(posedge clk);
        cfg_write <= 1'b0;
        line_length  = cycles;
        frame_length = lines;
    endtask

    function automatic reg_idx_t pick_special_reg(input int n);
        case (n)
            0:       return REG_CTRL1;
            1:       return REG_RASTER;
            2:       return REG_CTRL2;
            3:       return REG_MEMPTR;
            4:       return REG_LATCH;
            5:       return REG_ENABLE;
            6:       return REG_COLL_SS;
            default: return REG_COLL_SD;
        endcase
    endfunction

    task automatic test_reset_state();
        send_item(KIND_READ, bus_addr(REG_LATCH), 8'h00);
        send_item(KIND_READ, bus_addr(REG_LATCH), 8'h00);
        send_item(KIND_READ, bus_addr(REG_CTRL1), 8'h00);
        send_item(KIND_READ, bus_addr(REG_RASTER), 8'h00);
        send_item(KIND_READ, bus_addr(REG_CTRL2), 8'h00);
        send_item(KIND_READ, bus_addr(REG_MEMPTR), 8'h00);
        send_item(KIND_READ, bus_addr(REG_ENABLE), 8'h00);
        send_item(KIND_READ, bus_addr(REG_COLL_SS), 8'h00);
        // Lowest and highest bus addresses both fold onto the register file.
        send_item(KIND_READ, 16'h0000, 8'h00);
        send_item(KIND_SPARE, 16'hFFFF, 8'hFF);
        send_item(KIND_WRITE, bus_addr(REG_ENABLE), 8'hFF);
    endtask

    task automatic test_register_writes();
        write_config(7'd4, 9'd6);
        send_item(KIND_WRITE, bus_addr(REG_RASTER), 8'h03);
        send_item(KIND_WRITE, bus_addr(REG_CTRL1), 8'h80);
        send_item(KIND_READ, bus_addr(REG_CTRL1), 8'h00);
        send_item(KIND_WRITE, bus_addr(REG_CTRL1), 8'h1B);
        send_item(KIND_WRITE, bus_addr(REG_ENABLE), 8'h01);
        send_item(KIND_WRITE, bus_addr(REG_LATCH), 8'hFF);
        send_item(KIND_WRITE, bus_addr(REG_COLL_SS), 8'hAA);
        send_item(KIND_READ, bus_addr(REG_COLL_SS), 8'h00);
        send_item(KIND_READ, bus_addr(REG_COLL_SS), 8'h00);
        send_item(KIND_WRITE, bus_addr(REG_COLL_SD), 8'h55);
        send_item(KIND_READ, bus_addr(REG_COLL_SD), 8'h00);
        send_item(KIND_WRITE, 16'h003F, 8'hFF);
        send_item(KIND_READ, bus_addr(6'h3F), 8'h00);
        // Tick on, then read the latch; the counter does not reach the compare line here.
        repeat (3) send_item(KIND_TICK, bus_addr(REG_LATCH), 8'h00);
        send_item(KIND_READ, bus_addr(REG_LATCH), 8'h00);
    endtask

    task automatic send_random_item();
        logic [1:0]        op;
        reg_idx_t          idx;
        logic [DATA_W-1:0] data;
        logic [LINE_W-1:0] target;
        logic [9:0]        upper;
        int                pick;

        pick = $urandom_range(0, 99);
        if (pick < 45)
            op = KIND_READ;
        else if (pick < 85)
            op = KIND_WRITE;
        else if (pick < 95)
            op = KIND_TICK;
        else
            op = KIND_SPARE;
        if ($urandom_range(0, 9) < 7)
            idx = pick_special_reg($urandom_range(0, 7));
        else
            idx = reg_idx_t'($urandom_range(0, REG_COUNT - 1));
        data   = DATA_W'($urandom_range(0, 255));
        upper  = 10'($urandom_range(0, 1023));
        // Keep the compare value mostly on a line the counter actually visits.
        target = LINE_W'($urandom_range(0, frame_length - 1));
        if (op == KIND_WRITE && $urandom_range(0, 4) != 0)
        begin
            if (idx == REG_RASTER)
                data = target[7:0];
            else if (idx == REG_CTRL1)
                data[7] = target[8];
        end
        // The base address has its low six bits clear, so any upper bits
        // select the same register.
        send_item(op, {upper, idx}, data);
    endtask

    task automatic test_random_phase(input logic [CYCLE_W-1:0] cycles,
                                     input logic [LINE_W-1:0] lines,
                                     input int count, input bit with_idling);
        write_config(cycles, lines);
        idle_on = with_idling;
        for (int i = 0; i < count; i++)
        begin
            if (i == count / 2)
                wait_for_drain();
            send_random_item();
        end
        idle_on = 1'b1;
    endtask

    initial
    begin
        reset_shadow();
        idle_on = 1'b1;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_state();
        test_register_writes();
        test_random_phase(7'd3, 9'd5, 400, 1'b1);
        test_random_phase(7'd1, 9'd511, 320, 1'b0);
        test_random_phase(7'd1, 9'd300, 250, 1'b1);
        test_random_phase(7'd127, 9'd2, 250, 1'b1);
        test_random_phase(7'd4, 9'd1, 200, 1'b1);
        test_random_phase(7'd2, 9'd3, 300, 1'b1);
        test_random_phase(7'd63, 9'd312, 100, 1'b0);

        wait_for_drain();
        if (mismatch_count == 0 && pending_raster_results.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
